// ----- hdl/bsed_pkg.sv -----
// Shared types and codes for the backslash escape decoder.
// Used by bsed_decode, bsed_outbuf and backslash_escape_decoder_core; no dependencies.
package bsed_pkg;

    // Input item kinds
    localparam logic [1:0] FUNC_TEXT  = 2'd0;
    localparam logic [1:0] FUNC_NEXT  = 2'd1;
    localparam logic [1:0] FUNC_FINAL = 2'd2;
    localparam logic [1:0] FUNC_RSVD  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_ESCAPES_ON = 1'b0;
    localparam logic CFG_NEWLINE_ON = 1'b1;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out;

    typedef struct packed {
        logic escapes_on;
        logic newline_on;
    } t_cfg;

    // Up to two results decoded from one item
    typedef struct packed {
        logic [1:0] count;
        t_out       res0;
        t_out       res1;
    } t_dec_res;

endpackage

// ----- hdl/bsed_decode.sv -----
// Escape decoder: one item in, up to two result bytes out, with sequence state.
// Depends on bsed_pkg.
module bsed_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  bsed_pkg::t_in     i_item,
    input  bsed_pkg::t_cfg    i_cfg,
    output bsed_pkg::t_dec_res o_res
);

    // Decode modes
    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_BSLASH = 3'd1;
    localparam logic [2:0] MODE_HEX0   = 3'd2;
    localparam logic [2:0] MODE_HEX1   = 3'd3;
    localparam logic [2:0] MODE_OCT0   = 3'd4;
    localparam logic [2:0] MODE_OCT1   = 3'd5;
    localparam logic [2:0] MODE_OCT2   = 3'd6;

    // Characters
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LB     = 8'h62;
    localparam logic [7:0] CH_LC     = 8'h63;
    localparam logic [7:0] CH_LE     = 8'h65;
    localparam logic [7:0] CH_LF_    = 8'h66;
    localparam logic [7:0] CH_LN     = 8'h6E;
    localparam logic [7:0] CH_LR     = 8'h72;
    localparam logic [7:0] CH_LT     = 8'h74;
    localparam logic [7:0] CH_LV     = 8'h76;
    localparam logic [7:0] CH_LX     = 8'h78;

    logic [2:0] r_mode,   n_mode;
    logic [8:0] r_digit,  n_digit;
    logic       r_halted, n_halted;

    logic [7:0] b;
    logic       is_dec, is_hex, is_oct, pl_esc;
    logic [3:0] hex_v;
    logic       put_a, put_b;
    logic [7:0] byte_a, byte_b;

    // Classify the incoming byte
    always_comb begin
        b      = i_item.data_byte;
        is_dec = (b >= CH_0) && (b <= CH_9);
        is_oct = (b >= CH_0) && (b <= CH_7);
        is_hex = is_dec || ((b >= CH_LA) && (b <= CH_LF_)) || ((b >= CH_UA) && (b <= CH_UF));
        hex_v  = is_dec ? b[3:0] : (b[3:0] + 4'd9);
        pl_esc = i_cfg.escapes_on && (b == CH_BSLASH);
    end

    // Next state and emitted bytes; byte_b slot carries the plain text byte or the separator
    always_comb begin
        n_mode   = r_mode;
        n_digit  = r_digit;
        n_halted = r_halted;
        put_a    = 1'b0;
        put_b    = 1'b0;
        byte_a   = b;
        byte_b   = b;
        if (i_item.func == bsed_pkg::FUNC_RSVD) begin
            // ignore
        end else if (r_halted) begin
            if (i_item.func == bsed_pkg::FUNC_FINAL) begin
                n_halted = 1'b0;
                n_mode   = MODE_NORMAL;
                n_digit  = 9'd0;
            end
        end else if (i_item.func == bsed_pkg::FUNC_TEXT) begin
            unique case (r_mode)
                MODE_BSLASH: begin
                    n_mode = MODE_NORMAL;
                    put_a  = 1'b1;
                    unique case (b)
                        CH_BSLASH: byte_a = CH_BSLASH;
                        CH_LA:     byte_a = CH_BEL;
                        CH_LB:     byte_a = CH_BS;
                        CH_LE:     byte_a = CH_ESC;
                        CH_LF_:    byte_a = CH_FF;
                        CH_LN:     byte_a = CH_LF;
                        CH_LR:     byte_a = CH_CR;
                        CH_LT:     byte_a = CH_TAB;
                        CH_LV:     byte_a = CH_VT;
                        CH_LC: begin
                            put_a    = 1'b0;
                            n_halted = 1'b1;
                        end
                        CH_LX: begin
                            put_a   = 1'b0;
                            n_mode  = MODE_HEX0;
                            n_digit = 9'd0;
                        end
                        CH_0: begin
                            put_a   = 1'b0;
                            n_mode  = MODE_OCT0;
                            n_digit = 9'd0;
                        end
                        default: begin
                            // unknown escape: backslash, then the byte itself
                            byte_a = CH_BSLASH;
                            put_b  = 1'b1;
                        end
                    endcase
                end
                MODE_HEX0: begin
                    if (is_hex) begin
                        n_digit = {5'd0, hex_v};
                        n_mode  = MODE_HEX1;
                    end else begin
                        n_mode = pl_esc ? MODE_BSLASH : MODE_NORMAL;
                        put_b  = !pl_esc;
                    end
                end
                MODE_HEX1: begin
                    n_digit = 9'd0;
                    put_a   = 1'b1;
                    if (is_hex) begin
                        n_mode = MODE_NORMAL;
                        byte_a = {r_digit[3:0], hex_v};
                    end else begin
                        byte_a = r_digit[7:0];
                        n_mode = pl_esc ? MODE_BSLASH : MODE_NORMAL;
                        put_b  = !pl_esc;
                    end
                end
                MODE_OCT0, MODE_OCT1: begin
                    if (is_oct) begin
                        n_digit = {r_digit[5:0], b[2:0]};
                        n_mode  = r_mode + 3'd1;
                    end else begin
                        put_a   = (r_mode == MODE_OCT1);
                        byte_a  = r_digit[7:0];
                        n_digit = 9'd0;
                        n_mode  = pl_esc ? MODE_BSLASH : MODE_NORMAL;
                        put_b   = !pl_esc;
                    end
                end
                MODE_OCT2: begin
                    n_digit = 9'd0;
                    put_a   = 1'b1;
                    if (is_oct) begin
                        n_mode = MODE_NORMAL;
                        byte_a = {r_digit[4:0], b[2:0]};
                    end else begin
                        byte_a = r_digit[7:0];
                        n_mode = pl_esc ? MODE_BSLASH : MODE_NORMAL;
                        put_b  = !pl_esc;
                    end
                end
                default: begin
                    n_mode = pl_esc ? MODE_BSLASH : MODE_NORMAL;
                    put_b  = !pl_esc;
                end
            endcase
        end else begin
            // End of argument: flush an open sequence, then the separator
            put_a  = (r_mode == MODE_BSLASH) || (r_mode == MODE_HEX1) ||
                     (r_mode == MODE_OCT1) || (r_mode == MODE_OCT2);
            byte_a = (r_mode == MODE_BSLASH) ? CH_BSLASH : r_digit[7:0];
            n_mode  = MODE_NORMAL;
            n_digit = 9'd0;
            if (i_item.func == bsed_pkg::FUNC_NEXT) begin
                put_b  = 1'b1;
                byte_b = CH_SPACE;
            end else begin
                put_b  = i_cfg.newline_on;
                byte_b = CH_LF;
            end
        end
    end

    // Pack the results in emission order
    always_comb begin
        o_res.count            = {1'b0, put_a} + {1'b0, put_b};
        o_res.res0.out_byte    = put_a ? byte_a : byte_b;
        o_res.res0.last_of_run = !(put_a && put_b);
        o_res.res1.out_byte    = byte_b;
        o_res.res1.last_of_run = 1'b1;
    end

    // Advance sequence state on each consumed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NORMAL;
            r_digit  <= 9'd0;
            r_halted <= 1'b0;
        end else if (i_en) begin
            r_mode   <= n_mode;
            r_digit  <= n_digit;
            r_halted <= n_halted;
        end
    end

    a_halt_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_halted) && $stable(r_mode) && $stable(r_digit))
        else $error("decode state changed without a consumed item");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_halted && i_item.func == bsed_pkg::FUNC_FINAL)
            |=> !r_halted && r_mode == MODE_NORMAL)
        else $error("final marker did not release halt");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> o_res.count == 2'd0)
        else $error("output produced while halted");

endmodule

// ----- hdl/bsed_outbuf.sv -----
// Two-entry result buffer: loads a decoded run, hands results out one per cycle while the consumer is ready.
// Depends on bsed_pkg.
module bsed_outbuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  bsed_pkg::t_dec_res  i_res,
    output logic                o_free,
    output logic                o_valid,
    output bsed_pkg::t_out      o_item,
    input  logic                i_ready
);

    logic [1:0]     r_cnt, n_cnt;
    bsed_pkg::t_out r_res0, n_res0;
    bsed_pkg::t_out r_res1, n_res1;
    logic           fire;

    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_res0;
    assign fire    = o_valid && i_ready;
    // Room for a new run once the buffer drains this cycle
    assign o_free  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_ready);

    // Load a run or shift out one result
    always_comb begin
        n_cnt  = r_cnt;
        n_res0 = r_res0;
        n_res1 = r_res1;
        if (i_load) begin
            n_cnt  = i_res.count;
            n_res0 = i_res.res0;
            n_res1 = i_res.res1;
        end else if (fire) begin
            n_cnt  = r_cnt - 2'd1;
            n_res0 = r_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res0 <= n_res0;
        r_res1 <= n_res1;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result buffer overfilled");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("run loaded while buffer busy");

    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_cnt == $past(i_res.count))
        else $error("buffer count does not match loaded run");

endmodule

// ----- hdl/backslash_escape_decoder_core.sv -----
// Top level of the backslash escape decoder: input register, config registers,
// decoder and result buffer. Depends on bsed_pkg, bsed_decode, bsed_outbuf.
//
//  Channel  Signals                                   Direction
//  in       i_in_valid / o_in_ready / i_in_item       item in  (func, data_byte)
//  out      o_out_valid / i_out_ready / o_out_item    item out (out_byte, last_of_run)
//  cfg      i_cfg_wr_en / i_cfg_index / i_cfg_data    register write, no handshake
//
// One item per cycle is accepted while the result buffer has room; each item passes
// the input register and then the result buffer before its first result is offered.
// An item that yields two results holds the input side while the result buffer
// drains its first entry.
// Reset (synchronous, active low) empties both stages and returns to plain text.
// A stalled output holds the buffer, and the input register holds until it frees.
module backslash_escape_decoder_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  bsed_pkg::t_in   i_in_item,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output bsed_pkg::t_out  o_out_item,
    input  logic            i_cfg_wr_en,
    input  logic            i_cfg_index,
    input  logic            i_cfg_data
);

    logic               r_in_valid, n_in_valid;
    bsed_pkg::t_in      r_in;
    bsed_pkg::t_cfg     r_cfg;
    bsed_pkg::t_dec_res dec_res;
    logic               buf_free;
    logic               consume;
    logic               take;

    assign consume    = r_in_valid && buf_free;
    assign o_in_ready = !r_in_valid || consume;
    assign take       = i_in_valid && o_in_ready;

    // Hold the item until the decoder consumes it
    always_comb begin
        n_in_valid = r_in_valid;
        if (take) begin
            n_in_valid = 1'b1;
        end else if (consume) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in <= i_in_item;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.escapes_on <= 1'b0;
            r_cfg.newline_on <= 1'b1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                bsed_pkg::CFG_ESCAPES_ON: r_cfg.escapes_on <= i_cfg_data;
                bsed_pkg::CFG_NEWLINE_ON: r_cfg.newline_on <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bsed_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (consume),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (dec_res)
    );

    bsed_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (consume),
        .i_res   (dec_res),
        .o_free  (buf_free),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .i_ready (i_out_ready)
    );

endmodule
